// ===== rtl/dsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dsc_pkg: shared types and constants of the depth splat colormap unit
// memory geometry, field widths, command and color request types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsc_pkg;

  localparam int MAX_COLS    = 1024;
  localparam int MAX_ROWS    = 512;
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int ADDR_W      = COL_W + ROW_W;

  localparam int PIX_COL_W   = 10;
  localparam int PIX_ROW_W   = 9;
  localparam int RANGE_W     = 16;
  localparam int CHAN_W      = 8;
  localparam int COLS_W      = 11;
  localparam int ROWS_W      = 10;
  localparam int XP_W        = PIX_COL_W + 2;
  localparam int YP_W        = PIX_ROW_W + 2;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = COLS_W;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd1;
  localparam logic [COLS_W-1:0] COLS_RESET = 11'd640;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 10'd480;

  localparam logic REQ_SPLAT = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // v = min(255, floor(t / 50)) with t = floor(range * 255 / 256)
  localparam int Q_W         = 11;
  localparam int PROD_W      = 27;
  localparam int RECIP       = 1311;
  localparam int RECIP_SHIFT = 16;
  localparam int DIV_Q       = 50;
  localparam int M50_W       = 17;

  localparam int WORD_W      = RANGE_W + 1;

  typedef struct packed {
    logic                 is_read;
    logic                 read_ok;
    logic [PIX_COL_W-1:0] col;
    logic [PIX_ROW_W-1:0] row;
    logic [RANGE_W-1:0]   range;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic               hit;
    logic [RANGE_W-1:0] range;
  } color_req_t;

  typedef enum logic [0:0] {
    ST_CLEAR,
    ST_RUN
  } eng_state_t;

endpackage

`default_nettype wire

// ===== rtl/dsc_if.sv =====
// ----------------------------------------------------------------------------
// dsc_if: channel interfaces of the depth splat colormap unit
// request, pixel result and configuration write channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dsc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [9:0]  pix_col;
  logic [8:0]  pix_row;
  logic [15:0] point_range;
  modport source (output valid, req_type, pix_col, pix_row, point_range, input ready);
  modport sink (input valid, req_type, pix_col, pix_row, point_range, output ready);
endinterface

interface dsc_pix_if;
  logic       valid;
  logic       ready;
  logic       pixel_hit;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  modport source (output valid, pixel_hit, blue, green, red, input ready);
  modport sink (input valid, pixel_hit, blue, green, red, output ready);
endinterface

interface dsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dsc_front.sv =====
// ----------------------------------------------------------------------------
// dsc_front: request intake
// classifies each request and holds it in a short command queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsc_front
  import dsc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  dsc_req_if.sink   req,
  input  wire logic hold,
  input  wire logic pop,
  output cmd_t      head,
  output logic      head_valid
);

  cmd_t              q [QUEUE_DEPTH];
  logic [QP_W-1:0]   wr_ptr;
  logic [QP_W-1:0]   rd_ptr;
  logic [QC_W-1:0]   count;
  logic [QC_W-1:0]   count_next;
  logic              accept;
  cmd_t              cmd_in;

  assign req.ready  = (count != QC_W'(QUEUE_DEPTH)) && !hold;
  assign accept     = req.valid && req.ready;
  assign head       = q[rd_ptr];
  assign head_valid = (count != '0);

  always_comb begin
    cmd_in.is_read = (req.req_type == REQ_READ);
    cmd_in.read_ok = ((PIX_COL_W + 1)'(req.pix_col) < (PIX_COL_W + 1)'(MAX_COLS)) &&
                     ((PIX_ROW_W + 1)'(req.pix_row) < (PIX_ROW_W + 1)'(MAX_ROWS));
    cmd_in.col     = req.pix_col;
    cmd_in.row     = req.pix_row;
    cmd_in.range   = req.point_range;
  end

  always_comb begin
    case ({accept, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) q[wr_ptr] <= cmd_in;
  end

endmodule

`default_nettype wire

// ===== rtl/dsc_engine.sv =====
// ----------------------------------------------------------------------------
// dsc_engine: pixel memory engine
// clears the pixel memory after reset, then, while a command waits and no read is held, runs splat
// read-modify-writes and read-and-clear accesses, one memory access per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsc_engine
  import dsc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [COLS_W-1:0] image_cols,
  input  wire logic [ROWS_W-1:0] image_rows,
  input  wire cmd_t              head,
  input  wire logic              head_valid,
  output logic                   pop,
  output logic                   clearing,
  input  wire logic              color_ready,
  output color_req_t             creq
);

  logic [WORD_W-1:0] mem [1 << ADDR_W];

  eng_state_t         state;
  eng_state_t         state_next;
  logic [ADDR_W-1:0]  clr_addr;
  logic [1:0]         dx;
  logic [1:0]         dy;
  logic [1:0]         dx_next;
  logic [1:0]         dy_next;
  logic               issue;

  logic [XP_W-1:0]    xp;
  logic [YP_W-1:0]    yp;
  logic [XP_W-1:0]    xv;
  logic [YP_W-1:0]    yv;
  logic               in_bounds;
  logic [ADDR_W-1:0]  rd_addr;

  logic               p1_valid;
  logic               p1_is_read;
  logic               p1_ok;
  logic [ADDR_W-1:0]  p1_addr;
  logic [RANGE_W-1:0] p1_range;
  logic [WORD_W-1:0]  rdata;

  logic               w_valid;
  logic [ADDR_W-1:0]  w_addr;
  logic [WORD_W-1:0]  w_data;

  logic [WORD_W-1:0]  cur;
  logic               wb_we;
  logic [WORD_W-1:0]  wb_data;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;

  assign clearing = (state == ST_CLEAR);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == {ADDR_W{1'b1}}) state_next = ST_RUN;
      end
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    issue   = 1'b0;
    pop     = 1'b0;
    dx_next = dx;
    dy_next = dy;
    case (state)
      ST_RUN: begin
        if (head_valid) begin
          if (head.is_read) begin
            if (color_ready && !(p1_valid && p1_is_read)) begin
              issue = 1'b1;
              pop   = 1'b1;
            end
          end else begin
            issue = 1'b1;
            if (dx == 2'd2) begin
              dx_next = 2'd0;
              if (dy == 2'd2) begin
                dy_next = 2'd0;
                pop     = 1'b1;
              end else begin
                dy_next = dy + 2'd1;
              end
            end else begin
              dx_next = dx + 2'd1;
            end
          end
        end
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  // neighbor at (col + dx - 1, row + dy - 1)
  always_comb begin
    xp = XP_W'(head.col) + XP_W'(dx);
    yp = YP_W'(head.row) + YP_W'(dy);
    xv = xp - 1'b1;
    yv = yp - 1'b1;
    in_bounds = (xp >= XP_W'(2)) && (xp <= XP_W'(image_cols)) && (xp <= XP_W'(MAX_COLS)) &&
                (yp >= YP_W'(2)) && (yp <= YP_W'(image_rows)) && (yp <= YP_W'(MAX_ROWS));
    if (head.is_read) begin
      rd_addr = {head.row[ROW_W-1:0], head.col[COL_W-1:0]};
    end else begin
      rd_addr = {yv[ROW_W-1:0], xv[COL_W-1:0]};
    end
  end

  always_comb begin
    cur        = (w_valid && (w_addr == p1_addr)) ? w_data : rdata;
    wb_we      = 1'b0;
    wb_data    = cur;
    creq.valid = p1_valid && p1_is_read;
    creq.hit   = p1_ok && cur[RANGE_W];
    creq.range = cur[RANGE_W-1:0];
    if (p1_valid && p1_ok) begin
      if (p1_is_read) begin
        wb_we   = 1'b1;
        wb_data = {1'b0, cur[RANGE_W-1:0]};
      end else if (!cur[RANGE_W] || (p1_range < cur[RANGE_W-1:0])) begin
        wb_we   = 1'b1;
        wb_data = {1'b1, p1_range};
      end
    end
  end

  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = wb_we;
      mem_waddr = p1_addr;
      mem_wdata = wb_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      dx       <= 2'd0;
      dy       <= 2'd0;
      p1_valid <= 1'b0;
      w_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      if (clearing) clr_addr <= clr_addr + 1'b1;
      dx       <= dx_next;
      dy       <= dy_next;
      p1_valid <= issue;
      w_valid  <= wb_we;
    end
  end

  always_ff @(posedge clk) begin
    p1_is_read <= head.is_read;
    p1_ok      <= head.is_read ? head.read_ok : in_bounds;
    p1_addr    <= rd_addr;
    p1_range   <= head.range;
    w_addr     <= p1_addr;
    w_data     <= wb_data;
  end

endmodule

`default_nettype wire

// ===== rtl/dsc_color.sv =====
// ----------------------------------------------------------------------------
// dsc_color: range to jet color pipeline
// scales the range to an 8-bit index and maps it through the jet ramp
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsc_color
  import dsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire color_req_t creq,
  output logic            color_ready,
  dsc_pix_if.source       pix
);

  logic               s1_valid;
  logic               s1_hit;
  logic [RANGE_W-1:0] s1_t;
  logic               s2_valid;
  logic               s2_hit;
  logic [RANGE_W-1:0] s2_t;
  logic [Q_W-1:0]     s2_q0;
  logic               s3_valid;
  logic               s3_hit;
  logic [CHAN_W-1:0]  s3_v;
  logic               o_valid;
  logic               o_hit;
  logic [CHAN_W-1:0]  o_blue;
  logic [CHAN_W-1:0]  o_green;
  logic [CHAN_W-1:0]  o_red;

  logic               o_load;
  logic               s3_load;
  logic               s2_load;
  logic               s1_load;

  logic [RANGE_W+CHAN_W-1:0] scaled;
  logic [PROD_W-1:0]         prod;
  logic [M50_W-1:0]          m50;
  logic [Q_W-1:0]            q;
  logic [CHAN_W-1:0]         v;
  logic [5:0]                w;
  logic [CHAN_W-1:0]         blue;
  logic [CHAN_W-1:0]         green;
  logic [CHAN_W-1:0]         red;

  assign o_load      = !o_valid || pix.ready;
  assign s3_load     = !s3_valid || o_load;
  assign s2_load     = !s2_valid || s3_load;
  assign s1_load     = !s1_valid || s2_load;
  assign color_ready = !s1_valid;

  assign pix.valid     = o_valid;
  assign pix.pixel_hit = o_hit;
  assign pix.blue      = o_blue;
  assign pix.green     = o_green;
  assign pix.red       = o_red;

  always_comb begin
    scaled = {creq.range, {CHAN_W{1'b0}}} - (RANGE_W + CHAN_W)'(creq.range);
    prod   = PROD_W'(s1_t) * PROD_W'(RECIP);
    m50    = M50_W'(s2_q0) * M50_W'(DIV_Q);
    q      = (m50 > M50_W'(s2_t)) ? s2_q0 - 1'b1 : s2_q0;
    v      = (q > Q_W'(255)) ? 8'd255 : q[CHAN_W-1:0];
  end

  always_comb begin
    w     = s3_v[5:0];
    blue  = '0;
    green = '0;
    red   = '0;
    case (s3_v[7:6])
      2'd0: begin
        blue  = 8'd255;
        green = {w, 2'b00};
      end
      2'd1: begin
        blue  = 8'd254 - {w, 2'b00};
        green = 8'd255;
      end
      2'd2: begin
        green = 8'd255;
        red   = 8'd2 + {w, 2'b00};
      end
      default: begin
        green = 8'd252 - {w, 2'b00};
        red   = 8'd255;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (s1_load) s1_valid <= creq.valid;
      if (s2_load) s2_valid <= s1_valid;
      if (s3_load) s3_valid <= s2_valid;
      if (o_load) o_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_hit <= creq.hit;
      s1_t   <= scaled[RANGE_W+CHAN_W-1:CHAN_W];
    end
    if (s2_load) begin
      s2_hit <= s1_hit;
      s2_t   <= s1_t;
      s2_q0  <= prod[PROD_W-1:RECIP_SHIFT];
    end
    if (s3_load) begin
      s3_hit <= s2_hit;
      s3_v   <= v;
    end
    if (o_load) begin
      o_hit   <= s3_hit;
      o_blue  <= s3_hit ? blue : '0;
      o_green <= s3_hit ? green : '0;
      o_red   <= s3_hit ? red : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/depth_splat_colormap_unit.sv =====
// ----------------------------------------------------------------------------
// depth_splat_colormap_unit: z-buffer depth splatting with jet color readback
// splats point ranges onto a 3x3 neighborhood keeping the minimum, and reads
// pixels back as jet colors while clearing them
// ----------------------------------------------------------------------------
// In the memory engine a splat transaction makes one read-modify-write of the
// pixel memory, which has separate read and write ports, per neighbor; a read
// transaction makes one read-and-clear access there, and its color result then passes the
// p1 register, the color stages s1, s2 and s3 and the output register in order.
// The engine issues a read only while color stage s1 is empty and no read is in p1.
// A 4-entry command queue takes requests while the engine works. After reset the
// engine clears all 524288 pixel memory entries (one entry per cycle) and accepts
// no request in that time; configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module depth_splat_colormap_unit
  import dsc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  dsc_req_if.sink   req,
  dsc_pix_if.source pix,
  dsc_cfg_if.sink   cfg
);

  logic [COLS_W-1:0] image_cols;
  logic [ROWS_W-1:0] image_rows;
  cmd_t              head;
  logic              head_valid;
  logic              pop;
  logic              clearing;
  logic              color_ready;
  color_req_t        creq;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_cols <= COLS_RESET;
      image_rows <= ROWS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_IMAGE_COLS: image_cols <= cfg.data[COLS_W-1:0];
        CFG_IMAGE_ROWS: image_rows <= cfg.data[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  dsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .hold       (clearing),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  dsc_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .image_cols  (image_cols),
    .image_rows  (image_rows),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .clearing    (clearing),
    .color_ready (color_ready),
    .creq        (creq)
  );

  dsc_color u_color (
    .clk         (clk),
    .rst         (rst),
    .creq        (creq),
    .color_ready (color_ready),
    .pix         (pix)
  );

endmodule

`default_nettype wire

// ===== sim/tb_depth_splat_colormap_unit.sv =====
// ----------------------------------------------------------------------------
// tb_depth_splat_colormap_unit: self-checking bench for the depth splat unit
// drives splat and read transactions through a queue-fed driver. A pixel-level
// model of the depth image predicts every color readback, and a monitor
// compares each one in order. Image bounds are changed between phases, and
// sender and receiver idle at varying rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_depth_splat_colormap_unit;
  import dsc_pkg::*;

  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 2_100_000;
  localparam int CELLS         = MAX_COLS * MAX_ROWS;
  localparam int RANGE_DIV     = 12800;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic                 req_type;
    logic [PIX_COL_W-1:0] col;
    logic [PIX_ROW_W-1:0] row;
    logic [RANGE_W-1:0]   range;
  } pixel_req_t;

  typedef struct packed {
    logic              hit;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_color_t;

  logic clk;
  logic rst;

  dsc_req_if req_ch();
  dsc_pix_if pix_ch();
  dsc_cfg_if cfg_ch();

  depth_splat_colormap_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .pix (pix_ch),
    .cfg (cfg_ch)
  );

  pixel_req_t         pending_reqs[$];
  pixel_color_t       expected_colors[$];
  bit                 hit_map [CELLS];
  logic [RANGE_W-1:0] depth_map [CELLS];
  int                 img_cols;
  int                 img_rows;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 n_pushed, n_taken, n_splats, n_reads, n_results, n_hits;
  int                 n_settings, n_errors;
  logic               req_fire;
  logic               cfg_fire;
  pixel_req_t         next_req;
  pixel_req_t         taken_req;
  pixel_color_t       want;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic pixel_color_t jet_color(int v);
    pixel_color_t c;
    int b, g, r;
    if (v < 64) begin
      b = 255; g = 4 * v; r = 0;
    end else if (v < 128) begin
      b = 510 - 4 * v; g = 255; r = 0;
    end else if (v < 192) begin
      b = 0; g = 255; r = 4 * v - 510;
    end else begin
      b = 0; g = 1020 - 4 * v; r = 255;
    end
    c.hit   = 1'b1;
    c.blue  = b[CHAN_W-1:0];
    c.green = g[CHAN_W-1:0];
    c.red   = r[CHAN_W-1:0];
    return c;
  endfunction

  function automatic void splat_neighborhood(pixel_req_t r);
    int x, y, idx;
    for (int di = -1; di <= 1; di++) begin
      for (int dj = -1; dj <= 1; dj++) begin
        x = int'(r.col) + di;
        y = int'(r.row) + dj;
        if (x <= 0 || y <= 0 || x >= img_cols || y >= img_rows) continue;
        if (x >= MAX_COLS || y >= MAX_ROWS) continue;
        idx = y * MAX_COLS + x;
        if (!hit_map[idx]) begin
          depth_map[idx] = r.range;
          hit_map[idx]   = 1'b1;
        end else if (r.range < depth_map[idx]) begin
          depth_map[idx] = r.range;
        end
      end
    end
  endfunction

  function automatic pixel_color_t read_and_clear(pixel_req_t r);
    pixel_color_t c;
    int idx, v;
    c = '0;
    if (r.col < MAX_COLS && r.row < MAX_ROWS) begin
      idx = int'(r.row) * MAX_COLS + int'(r.col);
      if (hit_map[idx]) begin
        v = (int'(depth_map[idx]) * 255) / RANGE_DIV;
        if (v > 255) v = 255;
        c = jet_color(v);
      end
      hit_map[idx] = 1'b0;
    end
    return c;
  endfunction

  function automatic int clamp(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int rand_range();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return $urandom_range(0, 1) ? 65535 : 0;
    if (pick <= 6) return $urandom_range(0, 13000);
    return $urandom_range(0, 65535);
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_errors < 40) $display("mismatch at %0t ns: %s", $time, msg);
    n_errors++;
  endtask

  task automatic push_item(input logic kind, input int col, input int row, input int rng);
    pixel_req_t r;
    r.req_type = kind;
    r.col      = col[PIX_COL_W-1:0];
    r.row      = row[PIX_ROW_W-1:0];
    r.range    = rng[RANGE_W-1:0];
    pending_reqs = {pending_reqs, r};
    n_pushed++;
    if (kind == REQ_SPLAT) n_splats++;
    else n_reads++;
  endtask

  task automatic wait_drained();
    while (n_taken != n_pushed || expected_colors.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[CFG_DATA_W-1:0];
    do @(negedge clk); while (!cfg_fire);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(input int cols, input int rows, input int sidle, input int rstall);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    write_reg(CFG_IMAGE_COLS, cols);
    write_reg(CFG_IMAGE_ROWS, rows);
    // unmapped indexes must leave the bounds alone
    write_reg(CFG_SPARE_2, $urandom_range(0, 2047));
    write_reg(CFG_SPARE_3, $urandom_range(0, 2047));
    n_settings++;
  endtask

  task automatic push_random(input int count, input int cols, input int rows);
    int done, cx, cy, cx_hi, cy_hi, n_spl, n_rd;
    cx_hi = (cols < MAX_COLS) ? cols : MAX_COLS - 1;
    cy_hi = (rows < MAX_ROWS) ? rows : MAX_ROWS - 1;
    done  = 0;
    while (done < count) begin
      if ($urandom_range(0, 4) == 0) begin
        push_item(1'($urandom_range(0, 1)), $urandom_range(0, 1023), $urandom_range(0, 511),
                  rand_range());
        done++;
      end else begin
        // splat a small cluster, then read back around it
        cx    = $urandom_range(0, cx_hi);
        cy    = $urandom_range(0, cy_hi);
        n_spl = $urandom_range(1, 4);
        n_rd  = $urandom_range(1, 6);
        repeat (n_spl) begin
          push_item(REQ_SPLAT, clamp(cx + int'($urandom_range(0, 2)) - 1, 1023),
                    clamp(cy + int'($urandom_range(0, 2)) - 1, 511), rand_range());
        end
        repeat (n_rd) begin
          push_item(REQ_READ, clamp(cx + int'($urandom_range(0, 4)) - 2, 1023),
                    clamp(cy + int'($urandom_range(0, 4)) - 2, 511), $urandom_range(0, 65535));
        end
        done += n_spl + n_rd;
      end
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= next_req.req_type;
        req_ch.pix_col     <= next_req.col;
        req_ch.pix_row     <= next_req.row;
        req_ch.point_range <= next_req.range;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pix_ch.ready <= 1'b0;
    end else begin
      pix_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor and predictor update
  always @(posedge clk) begin
    if (rst) begin
      req_fire <= 1'b0;
      cfg_fire <= 1'b0;
    end else begin
      req_fire <= req_ch.valid && req_ch.ready;
      cfg_fire <= cfg_ch.valid && cfg_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_IMAGE_COLS: img_cols = int'(cfg_ch.data);
          CFG_IMAGE_ROWS: img_rows = int'(cfg_ch.data[ROWS_W-1:0]);
          default: ;
        endcase
      end
      if (pix_ch.valid && pix_ch.ready) begin
        n_results++;
        if (expected_colors.size() == 0) begin
          report_mismatch("color transaction with no read outstanding");
        end else begin
          want = expected_colors.pop_front();
          if (want.hit) n_hits++;
          if (pix_ch.pixel_hit !== want.hit)
            report_mismatch($sformatf("pixel_hit %0b, expected %0b", pix_ch.pixel_hit, want.hit));
          if (pix_ch.blue !== want.blue)
            report_mismatch($sformatf("blue %0d, expected %0d", pix_ch.blue, want.blue));
          if (pix_ch.green !== want.green)
            report_mismatch($sformatf("green %0d, expected %0d", pix_ch.green, want.green));
          if (pix_ch.red !== want.red)
            report_mismatch($sformatf("red %0d, expected %0d", pix_ch.red, want.red));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        taken_req.req_type = req_ch.req_type;
        taken_req.col      = req_ch.pix_col;
        taken_req.row      = req_ch.pix_row;
        taken_req.range    = req_ch.point_range;
        n_taken++;
        if (taken_req.req_type == REQ_SPLAT) splat_neighborhood(taken_req);
        else expected_colors = {expected_colors, read_and_clear(taken_req)};
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (pix_ch.valid && pix_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("no transaction for %0d cycles", STALL_LIMIT);
    $display("[depth_splat_colormap_unit] ERROR");
    $finish;
  end

  initial begin
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = 1'b0;
    req_ch.pix_col     = '0;
    req_ch.pix_row     = '0;
    req_ch.point_range = '0;
    pix_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    img_cols           = int'(COLS_RESET);
    img_rows           = int'(ROWS_RESET);
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    n_pushed = 0; n_taken = 0; n_splats = 0; n_reads = 0;
    n_results = 0; n_hits = 0; n_settings = 0; n_errors = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // small image so every edge is easy to reach
    configure(16, 10, 0, 0);
    push_item(REQ_READ, 5, 5, 0);
    push_item(REQ_SPLAT, 0, 0, 1000);
    push_item(REQ_READ, 1, 1, 0);
    push_item(REQ_READ, 0, 0, 0);
    push_item(REQ_SPLAT, 15, 9, 0);
    push_item(REQ_READ, 15, 9, 0);
    push_item(REQ_READ, 14, 8, 0);
    push_item(REQ_READ, 16, 9, 0);
    push_item(REQ_SPLAT, 5, 5, 65535);
    push_item(REQ_SPLAT, 4, 4, 6400);
    push_item(REQ_READ, 6, 6, 0);
    push_item(REQ_READ, 5, 5, 0);
    push_item(REQ_READ, 3, 3, 0);
    push_item(REQ_READ, 5, 5, 0);
    push_item(REQ_SPLAT, 12, 2, 5000);
    push_item(REQ_SPLAT, 12, 2, 5000);
    push_item(REQ_READ, 12, 2, 0);
    // jet segment boundaries
    push_item(REQ_SPLAT, 2, 7, 3200);
    push_item(REQ_SPLAT, 5, 7, 3213);
    push_item(REQ_SPLAT, 8, 7, 6426);
    push_item(REQ_SPLAT, 11, 7, 9638);
    push_item(REQ_SPLAT, 14, 7, 12800);
    push_item(REQ_READ, 2, 7, 0);
    push_item(REQ_READ, 5, 7, 0);
    push_item(REQ_READ, 8, 7, 0);
    push_item(REQ_READ, 11, 7, 0);
    push_item(REQ_READ, 14, 7, 0);
    push_item(REQ_SPLAT, 1023, 511, 65535);
    push_item(REQ_READ, 1023, 511, 65535);

    configure(1024, 512, 0, 0);
    push_random(138, 1024, 512);
    configure(1, 1, 86, 0);
    push_random(138, 1, 1);
    configure(2047, 1023, 0, 86);
    push_random(138, 2047, 1023);
    configure(37, 23, 18, 18);
    push_random(138, 37, 23);
    configure(640, 480, 0, 0);
    push_random(138, 640, 480);
    configure(2, 512, 18, 18);
    push_random(138, 2, 512);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_colors.size() != 0)
      report_mismatch($sformatf("%0d reads never answered", expected_colors.size()));

    $display("%0d splats and %0d reads under %0d bound settings", n_splats, n_reads,
             n_settings);
    $display("%0d colors checked, %0d on hit pixels, %0d mismatches", n_results, n_hits,
             n_errors);
    if (n_errors == 0) begin
      $display("[depth_splat_colormap_unit] OK");
    end else begin
      $display("[depth_splat_colormap_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dsc_pkg.sv
rtl/dsc_if.sv
rtl/dsc_front.sv
rtl/dsc_engine.sv
rtl/dsc_color.sv
rtl/depth_splat_colormap_unit.sv
sim/tb_depth_splat_colormap_unit.sv
